@@ rtl/qpht_pkg.sv @@
// qpht_pkg: shared constants, codes and types for the quadratic probe hash table
// no dependencies; compiled first
`timescale 1ns / 1ps
`default_nettype none

package qpht_pkg;

  // payload widths
  localparam int KEY_W    = 31;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SLOT_O_W = 3;

  // default table size
  localparam int TABLE_SLOTS_DEF = 7;

  // remainder unit: key bits consumed per cycle and number of cycles
  localparam int DIG       = 4;
  localparam int MOD_STEPS = (KEY_W + DIG - 1) / DIG;
  localparam int MOD_W     = MOD_STEPS * DIG;
  localparam int MCNT_W    = (MOD_STEPS > 1) ? $clog2(MOD_STEPS) : 1;

  // operation codes
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DELETE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // result codes
  localparam logic [STATUS_W-1:0] STAT_DONE   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOD,
    S_PROBE,
    S_RESP
  } state_t;

endpackage : qpht_pkg

`default_nettype wire

@@ rtl/qpht_if.sv @@
// qpht_in_if / qpht_out_if: valid/ready channels of the hash table
// depends on qpht_pkg for payload widths
`timescale 1ns / 1ps
`default_nettype none

interface qpht_in_if;
  logic                          valid;
  logic                          ready;
  logic [qpht_pkg::KIND_W-1:0]   kind;
  logic [qpht_pkg::KEY_W-1:0]    key;

  modport source (output valid, output kind, output key, input ready);
  modport sink   (input valid, input kind, input key, output ready);
endinterface : qpht_in_if

interface qpht_out_if;
  logic                          valid;
  logic                          ready;
  logic [qpht_pkg::STATUS_W-1:0] status;
  logic [qpht_pkg::SLOT_O_W-1:0] slot;
  logic [qpht_pkg::SLOT_O_W-1:0] home_slot;

  modport source (output valid, output status, output slot, output home_slot, input ready);
  modport sink   (input valid, input status, input slot, input home_slot, output ready);
endinterface : qpht_out_if

`default_nettype wire

@@ rtl/quadratic_probe_hash_table_unit.sv @@
// quadratic_probe_hash_table_unit: open-addressed hash table, quadratic probing
// depends on qpht_pkg and the channel interfaces in qpht_if.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                      notes
// in_ch     in   kind[1:0], key[30:0]         one operation per transaction
// out_ch    out  status[1:0], slot[2:0],      one result per operation,
//                home_slot[2:0]               held in an output register
//
// steps: the operation is accepted in the idle state, the remainder unit folds in 4 key
//   bits a cycle, the probe walk reads one slot a cycle and checks it against the
//   registered key memory read, and the result register is loaded last
// reset: synchronous active low; clears the used bits and the control state only
// stalls: a new transaction is taken while a result still waits; the sequencer
//   holds in the result state until the output register is free

module quadratic_probe_hash_table_unit #(
  parameter int TABLE_SLOTS = qpht_pkg::TABLE_SLOTS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  qpht_in_if.sink    in_ch,
  qpht_out_if.source out_ch
);
  import qpht_pkg::*;

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int REM_W  = SLOT_W + 1;
  localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);

  localparam logic [REM_W-1:0] N_REM = REM_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(TABLE_SLOTS);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(TABLE_SLOTS - 1);
  localparam logic [MCNT_W-1:0] MOD_LAST = MCNT_W'(MOD_STEPS - 1);

  // sequencer and operation registers
  state_t              state_r, state_nxt;
  logic [KIND_W-1:0]   kind_r, kind_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [MOD_W-1:0]    key_sh_r, key_sh_nxt;
  logic [REM_W-1:0]    rem_r, rem_nxt;
  logic [MCNT_W-1:0]   mod_cnt_r, mod_cnt_nxt;

  // probe walk: slot, step increment (2i+1 mod n), probes issued
  logic [SLOT_W-1:0]   p_r, p_nxt;
  logic [SLOT_W-1:0]   d_r, d_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;

  // check stage, aligned with the registered memory read
  logic                chk_v_r, chk_v_nxt;
  logic [SLOT_W-1:0]   chk_p_r, chk_p_nxt;
  logic                chk_last_r, chk_last_nxt;

  // running result
  logic                found_r, found_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SLOT_W-1:0]   res_slot_r, res_slot_nxt;

  logic [TABLE_SLOTS-1:0] used_r, used_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SLOT_O_W-1:0] out_slot_r, out_slot_nxt;
  logic [SLOT_O_W-1:0] out_home_r, out_home_nxt;

  // key memory
  logic [KEY_W-1:0]    key_mem [TABLE_SLOTS];
  logic [KEY_W-1:0]    key_rd_r;
  logic                mem_we;

  // combinational helpers
  logic [REM_W-1:0]    mod_rem;
  logic [REM_W-1:0]    mod_t;
  logic [REM_W-1:0]    p_sum;
  logic [REM_W-1:0]    d_sum;
  logic                hit;
  logic [SLOT_W+SLOT_O_W-1:0] slot_ext;
  logic [SLOT_W+SLOT_O_W-1:0] home_ext;

  // remainder step: DIG bits of the key folded into rem, one compare-subtract each
  always_comb begin
    mod_t   = '0;
    mod_rem = rem_r;
    for (int j = 0; j < DIG; j++) begin
      mod_t = {mod_rem[REM_W-2:0], key_sh_r[MOD_W-1-j]};
      if (mod_t >= N_REM) begin
        mod_t = mod_t - N_REM;
      end
      mod_rem = mod_t;
    end
  end

  // next probe slot and next increment, both reduced by one subtract
  always_comb begin
    p_sum = {1'b0, p_r} + {1'b0, d_r};
    if (p_sum >= N_REM) begin
      p_sum = p_sum - N_REM;
    end
    d_sum = {1'b0, d_r} + REM_W'(2);
    if (d_sum >= N_REM) begin
      d_sum = d_sum - N_REM;
    end
  end

  assign hit      = used_r[chk_p_r] && (key_rd_r == key_r);
  assign slot_ext = {{SLOT_O_W{1'b0}}, res_slot_r};
  assign home_ext = {{SLOT_O_W{1'b0}}, rem_r[SLOT_W-1:0]};

  assign in_ch.ready      = (state_r == S_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = out_status_r;
  assign out_ch.slot      = out_slot_r;
  assign out_ch.home_slot = out_home_r;

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    key_sh_nxt     = key_sh_r;
    rem_nxt        = rem_r;
    mod_cnt_nxt    = mod_cnt_r;
    p_nxt          = p_r;
    d_nxt          = d_r;
    cnt_nxt        = cnt_r;
    chk_v_nxt      = chk_v_r;
    chk_p_nxt      = chk_p_r;
    chk_last_nxt   = chk_last_r;
    found_nxt      = found_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    used_nxt       = used_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_home_nxt   = out_home_r;
    mem_we         = 1'b0;

    // result taken downstream
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          kind_nxt    = in_ch.kind;
          key_nxt     = in_ch.key;
          key_sh_nxt  = MOD_W'(in_ch.key);
          rem_nxt     = '0;
          mod_cnt_nxt = '0;
          state_nxt   = S_MOD;
        end
      end

      S_MOD: begin
        rem_nxt     = mod_rem;
        key_sh_nxt  = key_sh_r << DIG;
        mod_cnt_nxt = mod_cnt_r + MCNT_W'(1);
        if (mod_cnt_r == MOD_LAST) begin
          // home slot known: start the probe walk at i = 0
          p_nxt          = mod_rem[SLOT_W-1:0];
          d_nxt          = SLOT_W'(1);
          cnt_nxt        = '0;
          chk_v_nxt      = 1'b0;
          found_nxt      = 1'b0;
          res_slot_nxt   = '0;
          res_status_nxt = (kind_r == KIND_INSERT) ? STAT_FULL : STAT_ABSENT;
          state_nxt      = S_PROBE;
        end
      end

      S_PROBE: begin
        // issue stage: read key memory at the current probe slot
        if (cnt_r != N_CNT) begin
          chk_v_nxt    = 1'b1;
          chk_p_nxt    = p_r;
          chk_last_nxt = (cnt_r == LAST_CNT);
          p_nxt        = p_sum[SLOT_W-1:0];
          d_nxt        = d_sum[SLOT_W-1:0];
          cnt_nxt      = cnt_r + CNT_W'(1);
        end else begin
          chk_v_nxt = 1'b0;
        end

        // check stage
        if (chk_v_r) begin
          if (chk_last_r) begin
            state_nxt = S_RESP;
          end
          if (kind_r == KIND_INSERT) begin
            if (!used_r[chk_p_r]) begin
              mem_we            = 1'b1;
              used_nxt[chk_p_r] = 1'b1;
              res_status_nxt    = STAT_DONE;
              res_slot_nxt      = chk_p_r;
              state_nxt         = S_RESP;
            end
          end else if (kind_r == KIND_DELETE) begin
            // free every matching slot, report the first
            if (hit) begin
              used_nxt[chk_p_r] = 1'b0;
              if (!found_r) begin
                found_nxt      = 1'b1;
                res_status_nxt = STAT_DONE;
                res_slot_nxt   = chk_p_r;
              end
            end
          end else if (kind_r == KIND_SEARCH) begin
            if (hit) begin
              res_status_nxt = STAT_DONE;
              res_slot_nxt   = chk_p_r;
              state_nxt      = S_RESP;
            end
          end
          // unused kind: walk the probes with no effect
        end
      end

      S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = slot_ext[SLOT_O_W-1:0];
          out_home_nxt   = home_ext[SLOT_O_W-1:0];
          chk_v_nxt      = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_v_r     <= 1'b0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
      mod_cnt_r   <= '0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_v_r     <= chk_v_nxt;
      used_r      <= used_nxt;
      out_valid_r <= out_valid_nxt;
      mod_cnt_r   <= mod_cnt_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  // payload and datapath
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    key_sh_r     <= key_sh_nxt;
    rem_r        <= rem_nxt;
    p_r          <= p_nxt;
    d_r          <= d_nxt;
    chk_p_r      <= chk_p_nxt;
    chk_last_r   <= chk_last_nxt;
    found_r      <= found_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_home_r   <= out_home_nxt;
  end

  // key memory: one write port from the check stage, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      key_mem[chk_p_r] <= key_r;
    end
    key_rd_r <= key_mem[p_r];
  end

`ifndef SYNTHESIS
  // probe walk stays inside the table
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> ({1'b0, p_r} < N_REM && {1'b0, d_r} < N_REM))
    else $error("probe slot or increment out of range");

  // home slot is a proper remainder once the walk starts
  a_home_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (rem_r < N_REM))
    else $error("home slot out of range");

  // a full or absent answer never names a slot
  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != STAT_DONE) |-> (out_slot_r == '0))
    else $error("slot nonzero on a failed operation");

  // a new result only comes from the result state
  a_rose_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_RESP))
    else $error("result raised outside the result state");

  // a successful insert leaves its slot occupied
  a_insert_used: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> used_r[$past(chk_p_r)])
    else $error("inserted slot not marked used");
`endif

endmodule : quadratic_probe_hash_table_unit

`default_nettype wire

@@ bench/testbench.sv @@
// testbench: self-checking bench for quadratic_probe_hash_table_unit
// depends on qpht_pkg, the channel interfaces in qpht_if.sv and the unit itself
`timescale 1ns / 1ps

module testbench;
  import qpht_pkg::*;

  localparam int TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam int CLK_PERIOD  = 12;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_OPS  = 1850;
  // no transaction on either side for this long means the unit is hung
  localparam int WATCHDOG_LIMIT = 2000;
  // drain wait after the last result, longer than the worst operation time
  localparam int DRAIN_CYCLES = 40;
  // one long receiver hold-off, started once this many operations went in
  localparam int HOLD_AT_OP   = 300;
  localparam int HOLD_CYCLES  = 120;
  // window of operations with no idling on either side
  localparam int STEADY_FROM  = 900;
  localparam int STEADY_TO    = 1200;
  localparam int IDLE_PCT     = 13;

  // kind 3 has no meaning in the unit, it must answer not present
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX     = {KEY_W{1'b1}};

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_O_W-1:0] slot;
    logic [SLOT_O_W-1:0] home_slot;
  } lookup_result_t;

  // one row of the directed table; typed rows carry a result read off by hand
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key;
    bit                typed;
    lookup_result_t    want;
  } table_op_t;

  logic clk;
  logic rst_n;

  qpht_in_if  in_ch ();
  qpht_out_if out_ch ();

  quadratic_probe_hash_table_unit #(
    .TABLE_SLOTS(TABLE_SLOTS)
  ) DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // mirror of the table contents, kept in step with accepted operations
  logic [KEY_W-1:0] shadow_key  [TABLE_SLOTS];
  logic             shadow_used [TABLE_SLOTS];

  lookup_result_t expected_results[$];
  table_op_t      directed_ops[$];
  logic [KEY_W-1:0] recent_keys[$];

  int  error_count  = 0;
  int  ops_accepted = 0;
  int  ops_sent     = 0;
  int  quiet_cycles = 0;
  bit  steady       = 1'b0;
  bit  hold_done    = 1'b0;
  int  hold_left    = 0;

  // side info travelling with the payload of the current transaction
  bit             row_typed;
  lookup_result_t row_want;
  lookup_result_t predicted;

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // every input known from time zero
  initial begin
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.kind   = KIND_INSERT;
    in_ch.key    = '0;
    out_ch.ready = 1'b0;
    row_typed    = 1'b0;
    row_want     = '0;
    for (int s = 0; s < TABLE_SLOTS; s++) begin
      shadow_key[s]  = '0;
      shadow_used[s] = 1'b0;
    end
  end

  // apply one operation to the shadow table and return what the unit should answer
  function automatic lookup_result_t probe_table(input logic [KIND_W-1:0] kind,
                                                 input logic [KEY_W-1:0] key);
    lookup_result_t res;
    int unsigned    home;
    int unsigned    p;
    bit             hit;
    home          = int'(key) % TABLE_SLOTS;
    res.status    = STAT_ABSENT;
    res.slot      = '0;
    res.home_slot = SLOT_O_W'(home);
    hit           = 1'b0;
    case (kind)
      KIND_INSERT: begin
        res.status = STAT_FULL;
        for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
          p = (home + i * i) % TABLE_SLOTS;
          if (!hit && !shadow_used[p]) begin
            shadow_key[p]  = key;
            shadow_used[p] = 1'b1;
            res.status     = STAT_DONE;
            res.slot       = SLOT_O_W'(p);
            hit            = 1'b1;
          end
        end
      end
      KIND_DELETE: begin
        // every probe slot holding the key is freed, the first one is reported
        for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
          p = (home + i * i) % TABLE_SLOTS;
          if (shadow_used[p] && shadow_key[p] == key) begin
            shadow_used[p] = 1'b0;
            if (!hit) begin
              res.status = STAT_DONE;
              res.slot   = SLOT_O_W'(p);
              hit        = 1'b1;
            end
          end
        end
      end
      KIND_SEARCH: begin
        for (int unsigned i = 0; i < TABLE_SLOTS; i++) begin
          p = (home + i * i) % TABLE_SLOTS;
          if (!hit && shadow_used[p] && shadow_key[p] == key) begin
            res.status = STAT_DONE;
            res.slot   = SLOT_O_W'(p);
            hit        = 1'b1;
          end
        end
      end
      default: begin
        // unused kind: table untouched, not present
      end
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic add_op(input logic [KIND_W-1:0] kind, input logic [KEY_W-1:0] key,
                        input bit typed, input logic [STATUS_W-1:0] status,
                        input logic [SLOT_O_W-1:0] slot,
                        input logic [SLOT_O_W-1:0] home_slot);
    table_op_t row;
    row.kind           = kind;
    row.key            = key;
    row.typed          = typed;
    row.want.status    = status;
    row.want.slot      = slot;
    row.want.home_slot = home_slot;
    directed_ops.push_back(row);
  endtask

  // offer one transaction at the falling edge, idling first at random,
  // and return once it has been taken at a rising edge
  task automatic send_op(input table_op_t row);
    @(negedge clk);
    while (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.kind  <= row.kind;
    in_ch.key   <= row.key;
    row_typed   <= row.typed;
    row_want    <= row.want;
    @(posedge clk);
    while (!(in_ch.valid && in_ch.ready)) @(posedge clk);
    ops_sent++;
  endtask

  // random operation: often keys that were inserted lately so that
  // searches and deletes hit, plus small keys that collide a lot and wide ones
  function automatic table_op_t random_op();
    table_op_t   row;
    int unsigned pick;
    row       = '0;
    pick      = $urandom_range(99, 0);
    if (pick < 40)      row.kind = KIND_INSERT;
    else if (pick < 65) row.kind = KIND_DELETE;
    else if (pick < 95) row.kind = KIND_SEARCH;
    else                row.kind = KIND_UNUSED;
    pick = $urandom_range(99, 0);
    if (pick < 45 && recent_keys.size() != 0)
      row.key = recent_keys[$urandom_range(recent_keys.size() - 1, 0)];
    else if (pick < 80)
      row.key = KEY_W'($urandom_range(48, 0));
    else if (pick < 85)
      row.key = KEY_MAX - KEY_W'($urandom_range(20, 0));
    else
      row.key = KEY_W'($urandom());
    return row;
  endfunction

  // stimulus: reset, directed table, then random operations
  initial begin
    table_op_t row;
    // after reset nothing is present; kind 3 answers not present
    add_op(KIND_SEARCH, '0, 1'b1, STAT_ABSENT, '0, 3'd0);
    add_op(KIND_DELETE, KEY_MAX, 1'b1, STAT_ABSENT, '0, 3'd1);
    add_op(KIND_UNUSED, 31'd5, 1'b1, STAT_ABSENT, '0, 3'd5);
    // home slot 0 reaches only slots 0, 1, 4 and 2; the fifth insert finds it full
    add_op(KIND_INSERT, 31'd0, 1'b1, STAT_DONE, 3'd0, 3'd0);
    add_op(KIND_INSERT, 31'd7, 1'b0, '0, '0, '0);
    add_op(KIND_INSERT, 31'd14, 1'b0, '0, '0, '0);
    // duplicate key goes to the next free probe slot
    add_op(KIND_INSERT, 31'd0, 1'b0, '0, '0, '0);
    add_op(KIND_INSERT, 31'd21, 1'b1, STAT_FULL, '0, 3'd0);
    add_op(KIND_SEARCH, 31'd0, 1'b0, '0, '0, '0);
    // delete frees both copies of the duplicate
    add_op(KIND_DELETE, 31'd0, 1'b0, '0, '0, '0);
    add_op(KIND_SEARCH, 31'd0, 1'b1, STAT_ABSENT, '0, 3'd0);
    add_op(KIND_INSERT, KEY_MAX, 1'b0, '0, '0, '0);
    add_op(KIND_SEARCH, KEY_MAX, 1'b0, '0, '0, '0);
    add_op(KIND_INSERT, 31'h2AAA_AAAA, 1'b0, '0, '0, '0);
    add_op(KIND_INSERT, 31'h5555_5555, 1'b0, '0, '0, '0);
    add_op(KIND_SEARCH, 31'h5555_5555, 1'b0, '0, '0, '0);
    add_op(KIND_DELETE, 31'h2AAA_AAAA, 1'b0, '0, '0, '0);
    add_op(KIND_DELETE, 31'd7, 1'b0, '0, '0, '0);
    add_op(KIND_SEARCH, 31'd21, 1'b0, '0, '0, '0);
    add_op(KIND_UNUSED, KEY_MAX, 1'b1, STAT_ABSENT, '0, 3'd1);
    add_op(KIND_DELETE, KEY_MAX, 1'b0, '0, '0, '0);
    add_op(KIND_DELETE, 31'd14, 1'b0, '0, '0, '0);
    add_op(KIND_DELETE, 31'h5555_5555, 1'b0, '0, '0, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_ops[i]) send_op(directed_ops[i]);

    for (int n = 0; n < RANDOM_OPS; n++) begin
      steady = (n >= STEADY_FROM && n < STEADY_TO);
      row    = random_op();
      if (row.kind == KIND_INSERT) begin
        recent_keys.push_back(row.key);
        if (recent_keys.size() > 12) void'(recent_keys.pop_front());
      end
      send_op(row);
    end
    steady = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    // drain: the watchdog ends the run if results stop coming
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results still owed", 0, expected_results.size());
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // input monitor: each accepted transaction updates the shadow table
  // and queues what the unit has to answer
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predicted = probe_table(in_ch.kind, in_ch.key);
      if (row_typed) expected_results.push_back(row_want);
      else           expected_results.push_back(predicted);
      ops_accepted++;
    end
  end

  // result receiver: random stalls, one long hold-off so the unit backs up,
  // and no stalls during the steady window
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left    <= hold_left - 1;
    end else if (!hold_done && ops_accepted >= HOLD_AT_OP) begin
      out_ch.ready <= 1'b0;
      hold_done    <= 1'b1;
      hold_left    <= HOLD_CYCLES - 1;
    end else if (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with nothing pending, status", out_ch.status, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.status !== want.status)
          report_mismatch("status", out_ch.status, want.status);
        if (out_ch.slot !== want.slot)
          report_mismatch("slot", out_ch.slot, want.slot);
        if (out_ch.home_slot !== want.home_slot)
          report_mismatch("home_slot", out_ch.home_slot, want.home_slot);
      end
    end
  end

  // watchdog: counts cycles in which neither channel moves a transaction
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule : testbench
